// ===== rtl/pmp_pkg.sv =====
package pmp_pkg;

	localparam int SLOTS        = 16;
	localparam int POOL_ENTRIES = 64;
	localparam int BODY_MAX     = 256;

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int IDX_W  = $clog2(POOL_ENTRIES);
	localparam int PTR_W  = 7;
	localparam int KEY_W  = 5;
	localparam int CNT_W  = 7;

	localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_ENTRIES);

	localparam logic [2:0] OP_LOGIN  = 3'd0;
	localparam logic [2:0] OP_EXIT   = 3'd1;
	localparam logic [2:0] OP_SUB    = 3'd2;
	localparam logic [2:0] OP_UNSUB  = 3'd3;
	localparam logic [2:0] OP_SEND   = 3'd4;
	localparam logic [2:0] OP_RECV   = 3'd5;
	localparam logic [2:0] OP_TICK   = 3'd6;

	localparam logic [2:0] STS_OK      = 3'd0;
	localparam logic [2:0] STS_BAD_KEY = 3'd1;
	localparam logic [2:0] STS_NOT_REG = 3'd2;
	localparam logic [2:0] STS_EMPTY   = 3'd3;
	localparam logic [2:0] STS_NO_FREE = 3'd4;
	localparam logic [2:0] STS_BAD_LEN = 3'd5;

	typedef struct packed {
		logic [2:0]  operation;
		logic [4:0]  proc_key;
		logic [31:0] type_mask;
		logic [4:0]  source_key;
		logic [4:0]  msg_type;
		logic [15:0] msg_level;
		logic [14:0] lifetime;
		logic [8:0]  msg_length;
		logic [31:0] payload;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [4:0]         result_value;
		logic [4:0]         out_source_key;
		logic [4:0]         out_type;
		logic [15:0]        out_level;
		logic signed [15:0] out_lifetime;
		logic [8:0]         out_length;
		logic [31:0]        out_payload;
		logic [6:0]         free_entries;
		logic [6:0]         pending_count;
	} out_item_t;

	typedef struct packed {
		logic [4:0]         src;
		logic [4:0]         mtype;
		logic [15:0]        level;
		logic signed [15:0] life;
		logic [8:0]         len;
		logic [31:0]        payload;
	} msg_t;

	typedef struct packed {
		logic [2:0]        op;
		logic              key_ok;
		logic [SLOT_W-1:0] slot;
		logic [KEY_W-1:0]  pk;
		logic [31:0]       tmask;
		logic              len_bad;
		msg_t              msg;
	} cmd_t;

endpackage

// ===== rtl/pmp_front.sv =====
module pmp_front import pmp_pkg::*; (
	input  in_item_t item,
	output cmd_t     cmd
);

	always_comb begin
		cmd.op          = item.operation;
		cmd.key_ok      = (item.proc_key >= KEY_W'(1)) && (item.proc_key <= KEY_W'(SLOTS));
		cmd.slot        = SLOT_W'(item.proc_key - KEY_W'(1));
		cmd.pk          = item.proc_key;
		cmd.tmask       = item.type_mask;
		cmd.len_bad     = item.msg_length > 9'(BODY_MAX);
		cmd.msg.src     = item.source_key;
		cmd.msg.mtype   = item.msg_type;
		cmd.msg.level   = item.msg_level;
		cmd.msg.life    = $signed({1'b0, item.lifetime});
		cmd.msg.len     = item.msg_length;
		cmd.msg.payload = item.payload;
	end

endmodule

// ===== rtl/pmp_cmd_fifo.sv =====
module pmp_cmd_fifo import pmp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic avail,
	output cmd_t pop_data
);

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full     = cnt_q == 2'd2;
	assign avail    = cnt_q != 2'd0;
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== rtl/pmp_engine.sv =====
module pmp_engine import pmp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_avail,
	input  cmd_t      cmd_in,
	output logic      cmd_pop,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_EXEC      = 4'd1;
	localparam logic [3:0] S_SEND_SCAN = 4'd2;
	localparam logic [3:0] S_SEND_TAKE = 4'd3;
	localparam logic [3:0] S_SEND_LINK = 4'd4;
	localparam logic [3:0] S_RX_WAIT   = 4'd5;
	localparam logic [3:0] S_TICK_SLOT = 4'd6;
	localparam logic [3:0] S_TICK_ENT  = 4'd7;
	localparam logic [3:0] S_TICK_WAIT = 4'd8;
	localparam logic [3:0] S_TICK_FREE = 4'd9;
	localparam logic [3:0] S_DONE      = 4'd10;

	logic [3:0] state_q;
	cmd_t       cmd_q;
	out_item_t  res_q;
	out_item_t  res_fin;
	logic [KEY_W-1:0] pk_q;

	logic             in_use_q [SLOTS];
	logic [31:0]      mask_q   [SLOTS];
	logic [PTR_W-1:0] head_q   [SLOTS];
	logic [PTR_W-1:0] tail_q   [SLOTS];
	logic [CNT_W-1:0] pend_q   [SLOTS];

	logic [PTR_W-1:0] free_head_q, free_tail_q;
	logic [CNT_W-1:0] free_cnt_q;

	logic [SLOT_W-1:0] scan_q;
	logic [IDX_W-1:0]  e_q;
	logic [PTR_W-1:0]  cur_q, prev_q, hold_q;

	// next-pointer memory; entries never written read as their reset link i+1
	logic [PTR_W-1:0] nxt_mem [POOL_ENTRIES];
	logic [POOL_ENTRIES-1:0] nvalid_q;
	logic [PTR_W-1:0] nxt_rdata_q;
	logic             nxt_rv_q;
	logic [IDX_W-1:0] ra_q;
	msg_t             msg_mem [POOL_ENTRIES];
	msg_t             msg_rdata_q;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             nxt_we;
	logic [IDX_W-1:0] nxt_wa;
	logic [PTR_W-1:0] nxt_wd;
	logic             msg_we;
	logic [IDX_W-1:0] msg_wa;
	msg_t             msg_wd;

	logic [PTR_W-1:0] nxt_eff;
	logic signed [15:0] life_dec;
	logic             dead;
	logic             elig;
	logic             last_slot;
	logic             free_found;
	logic [SLOT_W-1:0] free_slot;
	logic             out_free;
	logic [SLOT_W-1:0] s;
	logic [SLOT_W-1:0] pk_idx;

	assign s         = cmd_q.slot;
	assign nxt_eff   = nxt_rv_q ? nxt_rdata_q : PTR_W'({1'b0, ra_q} + 7'd1);
	assign life_dec  = msg_rdata_q.life - 16'sd1;
	assign dead      = life_dec < 16'sd0;
	assign last_slot = scan_q == SLOT_W'(SLOTS - 1);
	assign elig      = in_use_q[scan_q]
	                   && (KEY_W'({1'b0, scan_q} + 5'd1) != cmd_q.msg.src)
	                   && mask_q[scan_q][cmd_q.msg.mtype];
	assign out_free  = !result_valid || !result_stall;
	assign cmd_pop   = (state_q == S_IDLE) && cmd_avail;
	assign pk_idx    = SLOT_W'(pk_q - KEY_W'(1));

	always_comb begin
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_slot  = SLOT_W'(i);
			end
		end
	end

	// final result word: counts are taken after the operation has settled
	always_comb begin
		res_fin               = res_q;
		res_fin.free_entries  = free_cnt_q;
		res_fin.pending_count = ((pk_q >= KEY_W'(1)) && (pk_q <= KEY_W'(SLOTS)))
		                        ? pend_q[pk_idx] : '0;
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		nxt_we  = 1'b0;
		nxt_wa  = '0;
		nxt_wd  = '0;
		msg_we  = 1'b0;
		msg_wa  = '0;
		msg_wd  = msg_rdata_q;
		case (state_q)
			S_EXEC: begin
				if (cmd_q.op == OP_EXIT && cmd_q.key_ok && head_q[s] < NIL
				    && free_cnt_q != '0) begin
					nxt_we = 1'b1;
					nxt_wa = free_tail_q[IDX_W-1:0];
					nxt_wd = head_q[s];
				end
				if (cmd_q.op == OP_RECV && cmd_q.key_ok && in_use_q[s] && head_q[s] < NIL) begin
					rd_en   = 1'b1;
					rd_addr = head_q[s][IDX_W-1:0];
				end
			end
			S_SEND_SCAN: begin
				if (elig && free_cnt_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = free_head_q[IDX_W-1:0];
				end
			end
			S_SEND_TAKE: begin
				nxt_we = 1'b1;
				nxt_wa = e_q;
				nxt_wd = NIL;
				msg_we = 1'b1;
				msg_wa = e_q;
				msg_wd = cmd_q.msg;
			end
			S_SEND_LINK: begin
				nxt_we = 1'b1;
				nxt_wa = tail_q[scan_q][IDX_W-1:0];
				nxt_wd = PTR_W'(e_q);
			end
			S_RX_WAIT, S_TICK_FREE: begin
				if (free_cnt_q != '0) begin
					nxt_we = 1'b1;
					nxt_wa = free_tail_q[IDX_W-1:0];
					nxt_wd = cur_q;
				end
			end
			S_TICK_ENT: begin
				if (cur_q < NIL) begin
					rd_en   = 1'b1;
					rd_addr = cur_q[IDX_W-1:0];
				end
			end
			S_TICK_WAIT: begin
				if (dead) begin
					if (prev_q < NIL) begin
						nxt_we = 1'b1;
						nxt_wa = prev_q[IDX_W-1:0];
						nxt_wd = nxt_eff;
					end
				end else begin
					msg_we      = 1'b1;
					msg_wa      = cur_q[IDX_W-1:0];
					msg_wd.life = life_dec;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		if (rd_en) nxt_rdata_q <= nxt_mem[rd_addr];
		if (msg_we) msg_mem[msg_wa] <= msg_wd;
		if (rd_en) msg_rdata_q <= msg_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nvalid_q <= '0;
			nxt_rv_q <= 1'b0;
			ra_q     <= '0;
		end else begin
			if (nxt_we) nvalid_q[nxt_wa] <= 1'b1;
			if (rd_en) begin
				nxt_rv_q <= nvalid_q[rd_addr];
				ra_q     <= rd_addr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) cmd_q <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			result_valid <= 1'b0;
			result       <= '0;
			res_q        <= '0;
			pk_q         <= '0;
			free_head_q  <= '0;
			free_tail_q  <= PTR_W'(POOL_ENTRIES - 1);
			free_cnt_q   <= CNT_W'(POOL_ENTRIES);
			scan_q       <= '0;
			e_q          <= '0;
			cur_q        <= NIL;
			prev_q       <= NIL;
			hold_q       <= NIL;
			for (int i = 0; i < SLOTS; i++) begin
				in_use_q[i] <= 1'b0;
				mask_q[i]   <= '0;
				head_q[i]   <= NIL;
				tail_q[i]   <= NIL;
				pend_q[i]   <= '0;
			end
		end else begin
			if (result_valid && !result_stall && state_q != S_DONE) result_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_avail) begin
						res_q   <= '0;
						pk_q    <= cmd_in.pk;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (cmd_q.op)
						OP_LOGIN: begin
							state_q <= S_DONE;
							if (free_found) begin
								in_use_q[free_slot] <= 1'b1;
								mask_q[free_slot]   <= '0;
								head_q[free_slot]   <= NIL;
								tail_q[free_slot]   <= NIL;
								pend_q[free_slot]   <= '0;
								res_q.result_value  <= KEY_W'({1'b0, free_slot} + 5'd1);
								pk_q                <= KEY_W'({1'b0, free_slot} + 5'd1);
							end else begin
								res_q.status <= STS_NO_FREE;
							end
						end
						OP_EXIT: begin
							state_q <= S_DONE;
							if (!cmd_q.key_ok) begin
								res_q.status <= STS_BAD_KEY;
							end else begin
								if (head_q[s] < NIL) begin
									if (free_cnt_q == '0) free_head_q <= head_q[s];
									free_tail_q <= tail_q[s];
									free_cnt_q  <= free_cnt_q + pend_q[s];
								end
								in_use_q[s] <= 1'b0;
								mask_q[s]   <= '0;
								head_q[s]   <= NIL;
								tail_q[s]   <= NIL;
								pend_q[s]   <= '0;
							end
						end
						OP_SUB, OP_UNSUB: begin
							state_q <= S_DONE;
							if (!cmd_q.key_ok) res_q.status <= STS_BAD_KEY;
							else if (!in_use_q[s]) res_q.status <= STS_NOT_REG;
							else if (cmd_q.op == OP_SUB) mask_q[s] <= mask_q[s] | cmd_q.tmask;
							else mask_q[s] <= mask_q[s] & ~cmd_q.tmask;
						end
						OP_SEND: begin
							if (cmd_q.len_bad) begin
								res_q.status <= STS_BAD_LEN;
								state_q      <= S_DONE;
							end else begin
								scan_q  <= '0;
								state_q <= S_SEND_SCAN;
							end
						end
						OP_RECV: begin
							if (!cmd_q.key_ok) begin
								res_q.status <= STS_BAD_KEY;
								state_q      <= S_DONE;
							end else if (!in_use_q[s]) begin
								res_q.status <= STS_NOT_REG;
								state_q      <= S_DONE;
							end else if (head_q[s] >= NIL) begin
								res_q.status <= STS_EMPTY;
								state_q      <= S_DONE;
							end else begin
								cur_q   <= head_q[s];
								state_q <= S_RX_WAIT;
							end
						end
						OP_TICK: begin
							scan_q  <= '0;
							state_q <= S_TICK_SLOT;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_SEND_SCAN: begin
					if (elig) begin
						if (free_cnt_q == '0) begin
							state_q <= S_DONE;
						end else begin
							e_q     <= free_head_q[IDX_W-1:0];
							state_q <= S_SEND_TAKE;
						end
					end else if (last_slot) begin
						state_q <= S_DONE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_SEND_TAKE, S_SEND_LINK: begin
					if (state_q == S_SEND_TAKE) begin
						free_cnt_q <= free_cnt_q - 1'b1;
						if (free_cnt_q == CNT_W'(1)) begin
							free_head_q <= NIL;
							free_tail_q <= NIL;
						end else begin
							free_head_q <= nxt_eff;
						end
						pend_q[scan_q]     <= pend_q[scan_q] + 1'b1;
						res_q.result_value <= res_q.result_value + 1'b1;
					end
					if (state_q == S_SEND_TAKE && head_q[scan_q] < NIL) begin
						state_q <= S_SEND_LINK;
					end else begin
						if (state_q == S_SEND_TAKE) head_q[scan_q] <= PTR_W'(e_q);
						tail_q[scan_q] <= PTR_W'(e_q);
						if (last_slot) state_q <= S_DONE;
						else begin
							scan_q  <= scan_q + 1'b1;
							state_q <= S_SEND_SCAN;
						end
					end
				end
				S_RX_WAIT: begin
					res_q.out_source_key <= msg_rdata_q.src;
					res_q.out_type       <= msg_rdata_q.mtype;
					res_q.out_level      <= msg_rdata_q.level;
					res_q.out_lifetime   <= msg_rdata_q.life;
					res_q.out_length     <= msg_rdata_q.len;
					res_q.out_payload    <= msg_rdata_q.payload;
					head_q[s] <= nxt_eff;
					if (nxt_eff >= NIL) tail_q[s] <= NIL;
					if (free_cnt_q == '0) free_head_q <= cur_q;
					free_tail_q <= cur_q;
					free_cnt_q  <= free_cnt_q + 1'b1;
					if (pend_q[s] != '0) pend_q[s] <= pend_q[s] - 1'b1;
					state_q <= S_DONE;
				end
				S_TICK_SLOT: begin
					cur_q   <= head_q[scan_q];
					prev_q  <= NIL;
					state_q <= S_TICK_ENT;
				end
				S_TICK_ENT: begin
					if (cur_q < NIL) state_q <= S_TICK_WAIT;
					else if (last_slot) state_q <= S_DONE;
					else begin
						scan_q  <= scan_q + 1'b1;
						state_q <= S_TICK_SLOT;
					end
				end
				S_TICK_WAIT: begin
					if (dead) begin
						if (prev_q >= NIL) head_q[scan_q] <= nxt_eff;
						if (tail_q[scan_q] == cur_q) tail_q[scan_q] <= prev_q;
						if (pend_q[scan_q] != '0) pend_q[scan_q] <= pend_q[scan_q] - 1'b1;
						hold_q  <= nxt_eff;
						state_q <= S_TICK_FREE;
					end else begin
						prev_q  <= cur_q;
						cur_q   <= nxt_eff;
						state_q <= S_TICK_ENT;
					end
				end
				S_TICK_FREE: begin
					if (free_cnt_q == '0) free_head_q <= cur_q;
					free_tail_q <= cur_q;
					free_cnt_q  <= free_cnt_q + 1'b1;
					cur_q       <= hold_q;
					state_q     <= S_TICK_ENT;
				end
				S_DONE: begin
					if (out_free) begin
						result       <= res_fin;
						result_valid <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/pubsub_message_pool_manager.sv =====
// Throughput: one item at a time in the back end; a 2-entry queue lets the front keep
// taking transfers, and the result register lets the next item start under a stalled result.
// Reset (arst_n low, asynchronous): all slots free, empty queues, whole pool on the free list.
module pubsub_message_pool_manager import pmp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	// front: decode key range and length check
	cmd_t dec_cmd;
	cmd_t q_cmd;
	logic q_full, q_avail, q_pop;

	pmp_front u_front (
		.item (item),
		.cmd  (dec_cmd)
	);

	// short command queue decouples intake from the list engine
	assign item_stall = q_full;

	pmp_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (item_valid && !q_full),
		.push_data (dec_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.avail     (q_avail),
		.pop_data  (q_cmd)
	);

	// back: free list, per-slot queues and message store
	pmp_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_avail    (q_avail),
		.cmd_in       (q_cmd),
		.cmd_pop      (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
